@@ rtl/cpmt_pkg.sv @@
`default_nettype none

package cpmt_pkg;

  // Width of the reported entry index.
  localparam int unsigned IDX_W = 4;

  // Longest legal prefix for each address family.
  localparam logic [7:0] V4_MAX_LEN = 8'd32;
  localparam logic [7:0] V6_MAX_LEN = 8'd128;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOMATCH = 2'd1,
    STAT_FORMERR = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Address being looked up.
  typedef struct packed {
    logic        is_v6;
    logic [63:0] hi;
    logic [63:0] lo;
  } key_t;

  // One stored CIDR block.
  typedef struct packed {
    logic        is_v6;
    logic [7:0]  len;
    logic [63:0] hi;
    logic [63:0] lo;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/cidr_prefix_match_table.sv @@
`default_nettype none

// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+---------------------------
// input     | in_kind in_is_v6 in_addr_hi in_addr_lo         | word taken when start high
//           | in_prefix_len                                  | and busy low
// result    | out_status out_entry_index                     | out_valid strobe, one cycle
//
// Add, clear and unused kinds, and a lookup on an empty table: the result word
// appears the cycle after the input word is taken, and busy stays low, so a
// word may be issued every cycle.
// Lookup: the word is issued, then the stored blocks are tried in turn, from 1 up to
// TABLE_DEPTH of them; the result strobes in the cycle after the last block tried.
// The single read port of the block table and the one comparator see one
// stored block per cycle; busy stays high while the scan runs.
// Reset (rst_n low, synchronous) empties the table; stored blocks are not
// cleared, since only blocks written since the last clear are ever read.
// The receiver cannot stall: each result word is shown for exactly one cycle.

module cidr_prefix_match_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_kind,
  input  wire logic                       in_is_v6,
  input  wire logic [63:0]                in_addr_hi,
  input  wire logic [63:0]                in_addr_lo,
  input  wire logic [7:0]                 in_prefix_len,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [cpmt_pkg::IDX_W-1:0]      out_entry_index
);

  // Table address width and block count width (the count must reach the
  // depth itself).
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  cpmt_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     scan_idx_r, scan_idx_nxt;
  cpmt_pkg::key_t    key_r;
  logic              key_ld;

  logic                          out_valid_r, out_valid_nxt;
  cpmt_pkg::status_t             out_status_r, out_status_nxt;
  logic [cpmt_pkg::IDX_W-1:0]    out_idx_r, out_idx_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  cpmt_pkg::entry_t  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  cpmt_pkg::entry_t  rd_data;
  logic              hit;

  logic              len_bad;
  logic              full;
  logic              last;

  // Narrows or widens a table index to the width of the reported index.
  function automatic logic [cpmt_pkg::IDX_W-1:0] to_idx(input logic [AW-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[cpmt_pkg::IDX_W-1:0];
  endfunction

  cpmt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cpmt_match u_match (
    .key   (key_r),
    .entry (rd_data),
    .hit   (hit)
  );

  // An IPv4 block keeps only the low 32 address bits; the rest are stored
  // as zero so that the comparator can treat the word as a whole.
  always_comb begin
    wr_addr       = AW'(count_r);
    wr_data.is_v6 = in_is_v6;
    wr_data.len   = in_prefix_len;
    wr_data.hi    = in_is_v6 ? in_addr_hi : 64'd0;
    wr_data.lo    = in_is_v6 ? in_addr_lo : {32'd0, in_addr_lo[31:0]};
    len_bad       = in_prefix_len >
                    (in_is_v6 ? cpmt_pkg::V6_MAX_LEN : cpmt_pkg::V4_MAX_LEN);
    full          = (count_r >= CW'(TABLE_DEPTH));
    last          = ((CW'(scan_idx_r) + CW'(1)) == count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpmt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    if (key_ld) begin
      key_r.is_v6 <= in_is_v6;
      key_r.hi    <= in_addr_hi;
      key_r.lo    <= in_addr_lo;
    end
  end

  // Sequencer: an idle state that answers everything but a lookup on a non-empty
  // table at once, and a scan state that tries one stored block per cycle.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = scan_idx_r + AW'(1);
    key_ld         = 1'b0;

    case (state_r)
      cpmt_pkg::ST_IDLE: begin
        if (start) begin
          out_idx_nxt = '0;
          case (in_kind)
            cpmt_pkg::KIND_ADD: begin
              out_valid_nxt = 1'b1;
              if (len_bad) begin
                out_status_nxt = cpmt_pkg::STAT_FORMERR;
              end else if (full) begin
                out_status_nxt = cpmt_pkg::STAT_FULL;
              end else begin
                out_status_nxt = cpmt_pkg::STAT_OK;
                out_idx_nxt    = to_idx(wr_addr);
                wr_en          = 1'b1;
                count_nxt      = count_r + CW'(1);
              end
            end
            cpmt_pkg::KIND_LOOKUP: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = cpmt_pkg::STAT_NOMATCH;
              end else begin
                key_ld       = 1'b1;
                rd_en        = 1'b1;
                rd_addr      = '0;
                scan_idx_nxt = '0;
                state_nxt    = cpmt_pkg::ST_SCAN;
              end
            end
            cpmt_pkg::KIND_CLEAR: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = cpmt_pkg::STAT_OK;
              count_nxt      = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = cpmt_pkg::STAT_FORMERR;
            end
          endcase
        end
      end
      cpmt_pkg::ST_SCAN: begin
        // The read data holds the block at scan_idx_r.
        if (hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cpmt_pkg::STAT_OK;
          out_idx_nxt    = to_idx(scan_idx_r);
          state_nxt      = cpmt_pkg::ST_IDLE;
        end else if (last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cpmt_pkg::STAT_NOMATCH;
          out_idx_nxt    = '0;
          state_nxt      = cpmt_pkg::ST_IDLE;
        end else begin
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = cpmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != cpmt_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;

  // A scan only runs over a non-empty table and stays inside the stored blocks.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpmt_pkg::ST_SCAN) |-> (count_r != '0))
    else $error("scan running over an empty table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpmt_pkg::ST_SCAN) |-> (CW'(scan_idx_r) < count_r))
    else $error("scan index beyond stored blocks");

  // Every accepted word either answers next cycle or starts a scan.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted word neither answered nor scanned");

  // No result is strobed while a scan is still running.
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobed during a scan");

  // A table-full answer only when the table really is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == cpmt_pkg::STAT_FULL)) |-> (count_r == CW'(TABLE_DEPTH)))
    else $error("table full reported on a table with room");

endmodule

`default_nettype wire

@@ rtl/cpmt_store.sv @@
`default_nettype none

// Block table: one write port and one registered read port.
module cpmt_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire cpmt_pkg::entry_t wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output cpmt_pkg::entry_t      rd_data
);

  cpmt_pkg::entry_t mem [DEPTH];
  cpmt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/cpmt_match.sv @@
`default_nettype none

// Shared compare unit: masks the looked-up address with the prefix of one
// stored block and compares it against the stored address.
module cpmt_match (
  input  wire cpmt_pkg::key_t   key,
  input  wire cpmt_pkg::entry_t entry,
  output logic                  hit
);

  logic [127:0] mask6;
  logic [31:0]  mask4;
  logic         eq6;
  logic         eq4;

  always_comb begin
    // Top len bits set; a shift by the full width yields zero, so len 128
    // gives a full mask and len 0 an empty one.
    mask6 = ~({128{1'b1}} >> entry.len);
    mask4 = ~({32{1'b1}} >> entry.len);
    eq6   = (({key.hi, key.lo} & mask6) == {entry.hi, entry.lo});
    eq4   = ({32'd0, key.lo[31:0] & mask4} == entry.lo);
    hit   = (key.is_v6 == entry.is_v6) && (key.is_v6 ? eq6 : eq4);
  end

endmodule

`default_nettype wire
